// File: hw/rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// Cubic Bezier flattener package
// Shared widths, stage counts and payload types of the curve flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int unsigned StepsDef = 20;
  localparam int unsigned StepsMax = 63;

  localparam int unsigned CoordW = 16;
  localparam int unsigned IdxW   = $clog2(StepsMax + 1);
  localparam int unsigned SqW    = 2 * IdxW;
  localparam int unsigned WgtW   = $clog2(StepsMax * StepsMax * StepsMax + 1);
  localparam int unsigned ProdW  = WgtW + 1 + CoordW;
  localparam int unsigned DivW   = 34;
  localparam int unsigned HalfW  = DivW / 2;
  localparam int unsigned RecW   = 31;
  localparam int unsigned PartW  = HalfW + RecW;
  localparam int unsigned QW     = CoordW + 1;
  localparam int unsigned DvsW   = $clog2(2 * StepsMax * StepsMax * StepsMax + 1);

  localparam int unsigned CoordStg = 8;
  localparam int unsigned NumStg   = CoordStg + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] ctrl_a_x;
    logic signed [CoordW-1:0] ctrl_a_y;
    logic signed [CoordW-1:0] ctrl_b_x;
    logic signed [CoordW-1:0] ctrl_b_y;
  } cbf_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] seg_from_x;
    logic signed [CoordW-1:0] seg_from_y;
    logic signed [CoordW-1:0] seg_to_x;
    logic signed [CoordW-1:0] seg_to_y;
    logic                     last_segment;
  } cbf_out_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            first;
    logic            last;
  } cbf_iss_t;

  typedef struct packed {
    logic [WgtW-1:0] w0;
    logic [WgtW-1:0] w1;
    logic [WgtW-1:0] w2;
    logic [WgtW-1:0] w3;
  } cbf_wgt_t;

endpackage

// File: hw/rtl/cbf_seq.sv
// ----------------------------------------------------------------------------
// Curve sequencer
// Holds one curve and issues its step indices, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module cbf_seq #(
  parameter int unsigned STEPS = cbf_pkg::StepsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cbf_pkg::cbf_in_t in_data_i,
  output logic             iss_valid_o,
  input  logic             iss_ready_i,
  output cbf_pkg::cbf_iss_t iss_o,
  output cbf_pkg::cbf_in_t cur_o
);
  import cbf_pkg::*;

  logic            busy_q, busy_d;
  logic [IdxW-1:0] idx_q, idx_d;
  cbf_in_t         cur_q;
  logic            at_end;
  logic            in_xfer;

  assign at_end     = (idx_q == IdxW'(STEPS));
  assign in_ready_o = !busy_q || (at_end && iss_ready_i);
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (in_xfer) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && iss_ready_i) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_q <= in_data_i;
    end
  end

  assign iss_valid_o = busy_q;
  assign iss_o.idx   = idx_q;
  assign iss_o.first = (idx_q == '0);
  assign iss_o.last  = at_end;
  assign cur_o       = cur_q;

endmodule

// File: hw/rtl/cbf_wgt.sv
// ----------------------------------------------------------------------------
// Bernstein weight stages
// Two pipeline stages that turn a step index into the four cubic weights.
// ----------------------------------------------------------------------------
module cbf_wgt #(
  parameter int unsigned STEPS = cbf_pkg::StepsDef
) (
  input  logic                     clk_i,
  input  logic [1:0]               ld_i,
  input  logic [cbf_pkg::IdxW-1:0] idx_i,
  output cbf_pkg::cbf_wgt_t        wgt_o
);
  import cbf_pkg::*;

  logic [IdxW-1:0] u_q, i_q;
  logic [SqW-1:0]  u2_q, i2_q;
  logic [IdxW-1:0] u_d;
  logic [WgtW-1:0] u2i, ui2;
  cbf_wgt_t        wgt_d, wgt_q;

  assign u_d = IdxW'(STEPS) - idx_i;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      u_q  <= u_d;
      i_q  <= idx_i;
      u2_q <= u_d * u_d;
      i2_q <= idx_i * idx_i;
    end
  end

  assign u2i = u2_q * i_q;
  assign ui2 = i2_q * u_q;

  always_comb begin
    wgt_d.w0 = u2_q * u_q;
    wgt_d.w1 = WgtW'({u2i, 1'b0} + {1'b0, u2i});
    wgt_d.w2 = WgtW'({ui2, 1'b0} + {1'b0, ui2});
    wgt_d.w3 = i2_q * i_q;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      wgt_q <= wgt_d;
    end
  end

  assign wgt_o = wgt_q;

endmodule

// File: hw/rtl/cbf_coord.sv
// ----------------------------------------------------------------------------
// Coordinate pipeline
// Weighted sum of one coordinate and rounded division by the cube of STEPS.
// ----------------------------------------------------------------------------
module cbf_coord #(
  parameter int unsigned STEPS = cbf_pkg::StepsDef
) (
  input  logic                              clk_i,
  input  logic [cbf_pkg::CoordStg-1:0]      ld_i,
  input  cbf_pkg::cbf_wgt_t                 wgt_i,
  input  logic signed [cbf_pkg::CoordW-1:0] p0_i,
  input  logic signed [cbf_pkg::CoordW-1:0] c1_i,
  input  logic signed [cbf_pkg::CoordW-1:0] c2_i,
  input  logic signed [cbf_pkg::CoordW-1:0] p3_i,
  output logic signed [cbf_pkg::CoordW-1:0] pt_o
);
  import cbf_pkg::*;

  localparam logic [63:0]     DenL  = 64'(STEPS) * 64'(STEPS) * 64'(STEPS);
  localparam logic [DivW-1:0] Den   = DivW'(DenL);
  localparam logic [DvsW-1:0] Dvs   = DvsW'(64'd2 * DenL);
  localparam logic [RecW-1:0] Recip = RecW'((64'd1 << DivW) / (64'd2 * DenL));

  logic signed [ProdW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic signed [ProdW-1:0] s01_q, s23_q, num_q;
  logic        [ProdW-1:0] mag;
  logic                    neg6_q, neg7_q, neg8_q, neg9_q;
  logic        [DivW-1:0]  x6_q, x7_q, x8_q, x9_q;
  logic        [PartW-1:0] phi_q, plo_q;
  logic [PartW+HalfW-1:0]  tot;
  logic        [QW-1:0]    qe_q, qe9_q;
  logic [QW+DvsW-1:0]      prod_full;
  logic        [DivW-1:0]  prod_q, rem;
  logic        [QW-1:0]    q, qs;
  logic signed [CoordW-1:0] pt_q;

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      m0_q <= $signed({1'b0, wgt_i.w0}) * p0_i;
      m1_q <= $signed({1'b0, wgt_i.w1}) * c1_i;
      m2_q <= $signed({1'b0, wgt_i.w2}) * c2_i;
      m3_q <= $signed({1'b0, wgt_i.w3}) * p3_i;
    end
    if (ld_i[1]) begin
      s01_q <= m0_q + m1_q;
      s23_q <= m2_q + m3_q;
    end
    if (ld_i[2]) begin
      num_q <= s01_q + s23_q;
    end
  end

  assign mag = num_q[ProdW-1] ? ProdW'(-num_q) : ProdW'(num_q);

  always_ff @(posedge clk_i) begin
    if (ld_i[3]) begin
      neg6_q <= num_q[ProdW-1];
      x6_q   <= {mag[DivW-2:0], 1'b0} + Den;
    end
    if (ld_i[4]) begin
      phi_q  <= x6_q[DivW-1:HalfW] * Recip;
      plo_q  <= x6_q[HalfW-1:0] * Recip;
      x7_q   <= x6_q;
      neg7_q <= neg6_q;
    end
  end

  assign tot = {phi_q, HalfW'(0)} + {HalfW'(0), plo_q};

  always_ff @(posedge clk_i) begin
    if (ld_i[5]) begin
      qe_q   <= tot[DivW +: QW];
      x8_q   <= x7_q;
      neg8_q <= neg7_q;
    end
  end

  assign prod_full = qe_q * Dvs;

  always_ff @(posedge clk_i) begin
    if (ld_i[6]) begin
      prod_q <= DivW'(prod_full);
      qe9_q  <= qe_q;
      x9_q   <= x8_q;
      neg9_q <= neg8_q;
    end
  end

  assign rem = x9_q - prod_q;
  assign q   = qe9_q + QW'(rem >= DivW'(Dvs));
  assign qs  = neg9_q ? (QW'(0) - q) : q;

  always_ff @(posedge clk_i) begin
    if (ld_i[7]) begin
      pt_q <= qs[CoordW-1:0];
    end
  end

  assign pt_o = pt_q;

endmodule

// File: hw/rtl/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// Cubic Bezier flattener
// Splits each cubic curve into STEPS+1 line segments at uniform parameter
// steps, with exact rounding of every point.
// ----------------------------------------------------------------------------
// Curves are taken one at a time and one segment leaves per cycle while the
// output is not stalled; the sequencer walks the step index of each curve,
// and the next curve is taken in the cycle its predecessor issues its closing
// step. A segment passes from its issue through two weight stages, eight
// stages of multiply, sum and reciprocal division per coordinate, and the
// output register. Each stage holds only while its result is blocked, so
// bubbles close up behind a stalled output.
module cubic_bezier_flattener #(
  parameter int unsigned STEPS = cbf_pkg::StepsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cbf_pkg::cbf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbf_pkg::cbf_out_t out_data_o
);
  import cbf_pkg::*;

  logic                     iss_valid;
  cbf_iss_t                 iss;
  cbf_in_t                  cur;
  cbf_in_t                  cur1_q, cur2_q;
  cbf_wgt_t                 wgt;
  logic [NumStg:1]          ld;
  logic                     ld_out;
  logic [NumStg:1]          v_q;
  logic [NumStg:1]          first_q, last_q;
  logic signed [CoordW-1:0] pt_x, pt_y;
  logic signed [CoordW-1:0] prev_x_q, prev_y_q;
  logic                     out_valid_q;
  cbf_out_t                 out_q;

  cbf_seq #(.STEPS(STEPS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .iss_valid_o (iss_valid),
    .iss_ready_i (ld[1]),
    .iss_o       (iss),
    .cur_o       (cur)
  );

  always_comb begin
    ld_out     = !out_valid_q || out_ready_i;
    ld[NumStg] = !v_q[NumStg] || ld_out;
    for (int k = NumStg - 1; k >= 1; k--) begin
      ld[k] = !v_q[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld[1]) begin
        v_q[1] <= iss_valid;
      end
      for (int k = 2; k <= NumStg; k++) begin
        if (ld[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (ld_out) begin
        out_valid_q <= v_q[NumStg];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      first_q[1] <= iss.first;
      last_q[1]  <= iss.last;
      cur1_q     <= cur;
    end
    if (ld[2]) begin
      cur2_q <= cur1_q;
    end
    for (int k = 2; k <= NumStg; k++) begin
      if (ld[k]) begin
        first_q[k] <= first_q[k-1];
        last_q[k]  <= last_q[k-1];
      end
    end
  end

  cbf_wgt #(.STEPS(STEPS)) u_wgt (
    .clk_i (clk_i),
    .ld_i  (ld[2:1]),
    .idx_i (iss.idx),
    .wgt_o (wgt)
  );

  cbf_coord #(.STEPS(STEPS)) u_coord_x (
    .clk_i (clk_i),
    .ld_i  (ld[NumStg:3]),
    .wgt_i (wgt),
    .p0_i  (cur2_q.start_x),
    .c1_i  (cur2_q.ctrl_a_x),
    .c2_i  (cur2_q.ctrl_b_x),
    .p3_i  (cur2_q.end_x),
    .pt_o  (pt_x)
  );

  cbf_coord #(.STEPS(STEPS)) u_coord_y (
    .clk_i (clk_i),
    .ld_i  (ld[NumStg:3]),
    .wgt_i (wgt),
    .p0_i  (cur2_q.start_y),
    .c1_i  (cur2_q.ctrl_a_y),
    .c2_i  (cur2_q.ctrl_b_y),
    .p3_i  (cur2_q.end_y),
    .pt_o  (pt_y)
  );

  always_ff @(posedge clk_i) begin
    if (ld_out && v_q[NumStg]) begin
      out_q.seg_from_x   <= first_q[NumStg] ? pt_x : prev_x_q;
      out_q.seg_from_y   <= first_q[NumStg] ? pt_y : prev_y_q;
      out_q.seg_to_x     <= pt_x;
      out_q.seg_to_y     <= pt_y;
      out_q.last_segment <= last_q[NumStg];
      prev_x_q           <= pt_x;
      prev_y_q           <= pt_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new curve holds the sequencer once taken; input is not ready right after.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after a curve transfer");

  // A blocked output keeps the segment queued behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && v_q[NumStg] |=> v_q[NumStg])
    else $error("last pipeline stage dropped a segment under stall");

  // Two closing segments never follow each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_segment
    |=> !out_valid_o || !out_data_o.last_segment)
    else $error("closing segment followed by another closing segment");

endmodule
